[rtl/rcfp_pkg.sv]
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types and constants for the RC channel frame packer.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  // Width of the raw channel value and of one frame byte.
  localparam int unsigned ChanValueW = 16;
  localparam int unsigned ByteW      = 8;

  // Packed channel width and its saturation limit.
  localparam int unsigned ChanBits   = 11;
  localparam logic [ChanValueW-1:0] ChanMax = 16'd2047;

  // Fixed frame bytes.
  localparam logic [ByteW-1:0] HeaderByte = 8'h0F;
  localparam logic [ByteW-1:0] FlagsByte  = 8'h00;

  // One input word produces at most this many bytes in one pass.
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CountW   = $clog2(MaxBytes + 1);

  // Default number of channels in one frame.
  localparam int unsigned NumChannelsDef = 16;

  // A group of bytes produced by one channel word, oldest in slot zero.
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [MaxBytes-1:0]            last;
    logic [CountW-1:0]              count;
  } burst_t;

endpackage

[rtl/rcfp_intf.sv]
// ----------------------------------------------------------------------------
// rcfp_intf
// Valid/ready channel interfaces for channel words and frame bytes.
// ----------------------------------------------------------------------------
interface rcfp_in_if;
  import rcfp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ChanValueW-1:0] channel_value;

  modport source (output valid, output channel_value, input ready);
  modport sink   (input valid, input channel_value, output ready);
endinterface

interface rcfp_out_if;
  import rcfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

[rtl/rcfp_packer.sv]
// ----------------------------------------------------------------------------
// rcfp_packer
// Input register, frame state and the single-pass byte assembly logic.
// ----------------------------------------------------------------------------
module rcfp_packer #(
  parameter int unsigned NumChannels = rcfp_pkg::NumChannelsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [rcfp_pkg::ChanValueW-1:0]  in_value_i,
  output logic                             in_ready_o,
  output rcfp_pkg::burst_t                 burst_o,
  output logic                             burst_valid_o,
  input  logic                             burst_ready_i
);
  import rcfp_pkg::*;

  localparam int unsigned IdxW = $clog2(NumChannels);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumChannels - 1);
  localparam int unsigned NumCand = 7;

  // Input register.
  logic                  item_vld_q, item_vld_d;
  logic [ChanValueW-1:0] item_q;

  // Frame state.
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [6:0]       acc_q, acc_d;
  logic [2:0]       held_q, held_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic             ckp_q, ckp_d;
  logic [ByteW-1:0] ckv_q, ckv_d;

  logic             take;
  logic [ChanBits-1:0] v_sat;
  logic [17:0]      wide;
  logic             two;
  logic [3:0]       sh0;
  logic [2:0]       sh1, rem;
  logic [ByteW-1:0] byte0, byte1, partial;
  logic [6:0]       acc_rem;
  logic             is_hdr, is_last, part_en;
  logic [ByteW-1:0] sum_new;

  logic [NumCand-1:0][ByteW-1:0] cand;
  logic [NumCand-1:0]            cand_en, cand_last;
  logic                          ck_defer;

  assign take          = item_vld_q && burst_ready_i;
  assign in_ready_o    = !item_vld_q || burst_ready_i;
  assign burst_valid_o = item_vld_q;
  assign item_vld_d    = (in_valid_i && in_ready_o) ? 1'b1 : (take ? 1'b0 : item_vld_q);

  // Bit packing of the saturated value behind the held bits.
  always_comb begin
    v_sat   = (item_q > ChanMax) ? ChanMax[ChanBits-1:0] : item_q[ChanBits-1:0];
    wide    = {acc_q, v_sat};
    two     = held_q >= 3'd5;
    sh0     = {1'b0, held_q} + 4'd3;
    sh1     = held_q - 3'd5;
    byte0   = 8'(wide >> sh0);
    byte1   = 8'(wide >> sh1);
    rem     = two ? (held_q - 3'd5) : (held_q + 3'd3);
    acc_rem = wide[6:0] & ((7'd1 << rem) - 7'd1);
    partial = 8'({acc_rem, 8'h00} >> rem);
    is_hdr  = idx_q == '0;
    is_last = idx_q == LastIdx;
    part_en = is_last && (rem != 3'd0);
    sum_new = sum_q + (is_hdr ? HeaderByte : 8'h00) + byte0 + (two ? byte1 : 8'h00)
              + (part_en ? partial : 8'h00);
  end

  // Ordered list of the bytes this word can cause.
  always_comb begin
    cand      = {sum_new, FlagsByte, partial, byte1, byte0, HeaderByte, ckv_q};
    cand_en   = {is_last, is_last, part_en, two, 1'b1, is_hdr, ckp_q};
    cand_last = 7'b1000001;
  end

  // Append the enabled bytes into the burst slots; a checksum that no longer
  // fits is held back for the next word.
  always_comb begin
    logic [CountW-1:0] cnt;
    cnt      = '0;
    ck_defer = 1'b0;
    burst_o  = '0;
    for (int i = 0; i < NumCand; i++) begin
      if (cand_en[i]) begin
        if (cnt != CountW'(MaxBytes)) begin
          burst_o.bytes[cnt[CountW-2:0]] = cand[i];
          burst_o.last[cnt[CountW-2:0]]  = cand_last[i];
          cnt = cnt + CountW'(1);
        end else begin
          ck_defer = 1'b1;
        end
      end
    end
    burst_o.count = cnt;
  end

  always_comb begin
    idx_d  = idx_q;
    acc_d  = acc_q;
    held_d = held_q;
    sum_d  = sum_q;
    ckp_d  = ckp_q;
    ckv_d  = ckv_q;
    if (take) begin
      ckp_d = 1'b0;
      if (is_last) begin
        idx_d  = '0;
        acc_d  = '0;
        held_d = '0;
        sum_d  = '0;
        ckp_d  = ck_defer;
        ckv_d  = sum_new;
      end else begin
        idx_d  = idx_q + IdxW'(1);
        acc_d  = acc_rem;
        held_d = rem;
        sum_d  = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      idx_q      <= '0;
      acc_q      <= '0;
      held_q     <= '0;
      sum_q      <= '0;
      ckp_q      <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      idx_q      <= idx_d;
      acc_q      <= acc_d;
      held_q     <= held_d;
      sum_q      <= sum_d;
      ckp_q      <= ckp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ckv_q <= ckv_d;
    if (in_valid_i && in_ready_o) begin
      item_q <= in_value_i;
    end
  end

endmodule

[rtl/rcfp_serializer.sv]
// ----------------------------------------------------------------------------
// rcfp_serializer
// Holds one burst of bytes and sends it out one byte per cycle while the output is ready.
// ----------------------------------------------------------------------------
module rcfp_serializer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rcfp_pkg::burst_t             burst_i,
  input  logic                         burst_valid_i,
  output logic                         burst_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rcfp_pkg::ByteW-1:0]   out_byte_o,
  output logic                         out_last_o
);
  import rcfp_pkg::*;

  logic [MaxBytes-1:0][ByteW-1:0] bytes_q, bytes_d;
  logic [MaxBytes-1:0]            last_q, last_d;
  logic [CountW-1:0]              cnt_q, cnt_d;
  logic                           out_take;

  assign out_valid_o   = cnt_q != '0;
  assign out_byte_o    = bytes_q[0];
  assign out_last_o    = last_q[0];
  assign out_take      = out_valid_o && out_ready_i;
  assign burst_ready_o = (cnt_q == '0) || ((cnt_q == CountW'(1)) && out_ready_i);

  always_comb begin
    bytes_d = bytes_q;
    last_d  = last_q;
    cnt_d   = cnt_q;
    if (burst_valid_i && burst_ready_o) begin
      bytes_d = burst_i.bytes;
      last_d  = burst_i.last;
      cnt_d   = burst_i.count;
    end else if (out_take) begin
      for (int j = 0; j < MaxBytes - 1; j++) begin
        bytes_d[j] = bytes_q[j+1];
        last_d[j]  = last_q[j+1];
      end
      cnt_d = cnt_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    last_q  <= last_d;
  end

endmodule

[rtl/rc_channel_frame_packer.sv]
// ----------------------------------------------------------------------------
// rc_channel_frame_packer
// Packs 11-bit channel values into framed bytes: header, data, flags, checksum.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                         handshake
//   in_i     sink       channel_value[15:0]             valid / ready
//   out_o    source     frame_byte[7:0], end_of_frame   valid / ready
//
// One channel word is taken into an input register, packed in a single
// combinational pass and handed as a burst of one to four bytes to the output
// register, which sends one byte per cycle while the output is ready. With 16
// channels a frame has 25 bytes. The next word is accepted while the previous
// burst is still being sent. Reset clears all frame state, so the first word
// after reset starts a new frame. A stall on the output holds the current byte
// and backs up into the input register.
// ----------------------------------------------------------------------------
module rc_channel_frame_packer #(
  parameter int unsigned NumChannels = rcfp_pkg::NumChannelsDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  rcfp_in_if.sink     in_i,
  rcfp_out_if.source  out_o
);
  import rcfp_pkg::*;

  // Burst handed from the packing stage to the output stage.
  burst_t burst;
  logic   burst_valid;
  logic   burst_ready;

  // The packer keeps the frame position, the held bits and the running sum.
  // A checksum that does not fit into the burst of the last channel is kept
  // back and leads the burst of the next word.
  rcfp_packer #(
    .NumChannels (NumChannels)
  ) u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_value_i    (in_i.channel_value),
    .in_ready_o    (in_i.ready),
    .burst_o       (burst),
    .burst_valid_o (burst_valid),
    .burst_ready_i (burst_ready)
  );

  // The serializer is the output register of the block.
  rcfp_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_i       (burst),
    .burst_valid_i (burst_valid),
    .burst_ready_o (burst_ready),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_byte_o    (out_o.frame_byte),
    .out_last_o    (out_o.end_of_frame)
  );

endmodule

[rtl/rcfp_checker.sv]
// ----------------------------------------------------------------------------
// rcfp_checker
// Port-level checks of the frame structure, bound to the top level.
// ----------------------------------------------------------------------------
module rcfp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [rcfp_pkg::ByteW-1:0]  out_byte_i,
  input logic                        out_last_i
);
  import rcfp_pkg::*;

  logic             acc;
  logic             start_q;
  logic [ByteW-1:0] prev_q;
  logic [ByteW-1:0] sum_q;

  assign acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      prev_q  <= '0;
      sum_q   <= '0;
    end else if (acc) begin
      start_q <= out_last_i;
      prev_q  <= out_byte_i;
      sum_q   <= out_last_i ? '0 : (sum_q + out_byte_i);
    end
  end

  // Every frame opens with the header byte.
  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && start_q |-> out_byte_i == HeaderByte)
    else $error("frame does not start with the header byte");

  // The flags byte directly precedes the closing checksum.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && out_last_i |-> prev_q == FlagsByte)
    else $error("checksum not preceded by the flags byte");

  // The closing byte is the sum of all earlier bytes of the frame.
  a_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && out_last_i |-> out_byte_i == sum_q)
    else $error("checksum byte mismatch");

  // A byte that is offered stays offered until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

endmodule

bind rc_channel_frame_packer rcfp_checker u_rcfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.frame_byte),
  .out_last_i  (out_o.end_of_frame)
);
